// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/jbcd_pkg.sv =====
// package: types and constants of the jtag byte command decoder
`default_nettype none

package jbcd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PIN_W   = 6;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned IDX_W   = 3;

    localparam int unsigned SHIFT_CMD_BIT = 7;
    localparam int unsigned READ_BIT      = 6;

    localparam logic [IDX_W-1:0]  LAST_BIT_IDX = 3'd7;
    localparam logic [BYTE_W-1:0] READ_STATUS  = 8'h02;
    localparam logic [BYTE_W-1:0] ALL_ONES     = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_HI,
        S_LO
    } t_state;

    typedef struct packed {
        logic accept;
        logic next_bit;
        logic tck_hi;
        logic end_phase;
    } t_dp_cmd;

    typedef struct packed {
        logic shift_active;
        logic enter_shift;
        logic last_bit;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/jbcd_if.sv =====
// item channel interfaces for host bytes and pin phase results
`default_nettype none

interface jbcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] host_byte;
    logic [7:0] tdo_bits;

    modport source (output valid, output host_byte, output tdo_bits, input ready);
    modport sink   (input valid, input host_byte, input tdo_bits, output ready);
endinterface

interface jbcd_out_if;
    logic       valid;
    logic       ready;
    logic       tck;
    logic       tms;
    logic       tdi;
    logic       nce_pin;
    logic       ncs_pin;
    logic       output_enable;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last;

    modport source (
        output valid, output tck, output tms, output tdi, output nce_pin,
        output ncs_pin, output output_enable, output read_valid,
        output read_byte, output last, input ready
    );
    modport sink (
        input valid, input tck, input tms, input tdi, input nce_pin,
        input ncs_pin, input output_enable, input read_valid,
        input read_byte, input last, output ready
    );
endinterface

`default_nettype wire

// ===== sv/jbcd_dp.sv =====
// datapath: pin levels, shift count, shift data and capture registers
`default_nettype none

module jbcd_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [jbcd_pkg::BYTE_W-1:0]   i_host_byte,
    input  wire logic [jbcd_pkg::BYTE_W-1:0]   i_tdo_bits,
    input  wire jbcd_pkg::t_dp_cmd             i_cmd,
    output jbcd_pkg::t_dp_stat                 o_stat,
    output logic                               o_tck,
    output logic                               o_tms,
    output logic                               o_tdi,
    output logic                               o_nce_pin,
    output logic                               o_ncs_pin,
    output logic                               o_output_enable,
    output logic                               o_read_valid,
    output logic [jbcd_pkg::BYTE_W-1:0]        o_read_byte,
    output logic                               o_last
);

    logic [jbcd_pkg::PIN_W-1:0]   r_pins;
    logic [jbcd_pkg::COUNT_W-1:0] r_left;
    logic                         r_rbo;
    logic [jbcd_pkg::BYTE_W-1:0]  r_data;
    logic [jbcd_pkg::BYTE_W-1:0]  r_cap;
    logic [jbcd_pkg::IDX_W-1:0]   r_idx;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins <= '0;
            r_left <= '0;
            r_rbo  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (o_stat.shift_active) begin
                    r_left <= r_left - jbcd_pkg::COUNT_W'(1);
                    r_pins <= {r_pins[5], i_host_byte[0], r_pins[3:1], 1'b0};
                end else begin
                    r_rbo <= i_host_byte[jbcd_pkg::READ_BIT];
                    if (i_host_byte[jbcd_pkg::SHIFT_CMD_BIT]) begin
                        r_left <= i_host_byte[jbcd_pkg::COUNT_W-1:0];
                    end else begin
                        r_pins <= i_host_byte[jbcd_pkg::PIN_W-1:0];
                    end
                end
            end
            if (i_cmd.next_bit) begin
                r_pins[4] <= r_data[1];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_data <= i_host_byte;
            r_idx  <= '0;
            if (o_stat.shift_active) begin
                // tdo only seen while ncs is high
                r_cap <= r_pins[3] ? i_tdo_bits : jbcd_pkg::ALL_ONES;
            end else begin
                r_cap <= jbcd_pkg::READ_STATUS | {7'b0, i_tdo_bits[0]};
            end
        end else if (i_cmd.next_bit) begin
            r_data <= {1'b0, r_data[7:1]};
            r_idx  <= r_idx + jbcd_pkg::IDX_W'(1);
        end
    end

    always_comb begin
        o_stat.shift_active = (r_left != '0);
        o_stat.enter_shift  = i_host_byte[jbcd_pkg::SHIFT_CMD_BIT];
        o_stat.last_bit     = (r_idx == jbcd_pkg::LAST_BIT_IDX);
    end

    assign o_tck           = i_cmd.tck_hi | r_pins[0];
    assign o_tms           = r_pins[1];
    assign o_nce_pin       = r_pins[2];
    assign o_ncs_pin       = r_pins[3];
    assign o_tdi           = r_pins[4];
    assign o_output_enable = r_pins[5];
    assign o_read_valid    = i_cmd.end_phase & r_rbo;
    assign o_read_byte     = o_read_valid ? r_cap : '0;
    assign o_last          = i_cmd.end_phase;

endmodule

`default_nettype wire

// ===== sv/jbcd_ctrl.sv =====
// controller: state machine sequencing commands and tck phases
`default_nettype none
`include "assert_macros.svh"

module jbcd_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire jbcd_pkg::t_dp_stat   i_stat,
    output jbcd_pkg::t_dp_cmd         o_cmd
);

    jbcd_pkg::t_state r_state;
    jbcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jbcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jbcd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.shift_active) begin
                        n_state = jbcd_pkg::S_HI;
                    end else if (!i_stat.enter_shift) begin
                        n_state = jbcd_pkg::S_CMD;
                    end
                end
            end
            jbcd_pkg::S_CMD: begin
                if (i_out_ready) begin
                    n_state = jbcd_pkg::S_IDLE;
                end
            end
            jbcd_pkg::S_HI: begin
                if (i_out_ready) begin
                    n_state = jbcd_pkg::S_LO;
                end
            end
            jbcd_pkg::S_LO: begin
                if (i_out_ready) begin
                    n_state = i_stat.last_bit ? jbcd_pkg::S_IDLE : jbcd_pkg::S_HI;
                end
            end
            default: begin
                n_state = jbcd_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready         = 1'b0;
        o_out_valid        = 1'b0;
        o_cmd.accept       = 1'b0;
        o_cmd.next_bit     = 1'b0;
        o_cmd.tck_hi       = 1'b0;
        o_cmd.end_phase    = 1'b0;
        case (r_state)
            jbcd_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            jbcd_pkg::S_CMD: begin
                o_out_valid     = 1'b1;
                o_cmd.end_phase = 1'b1;
            end
            jbcd_pkg::S_HI: begin
                o_out_valid  = 1'b1;
                o_cmd.tck_hi = 1'b1;
            end
            jbcd_pkg::S_LO: begin
                o_out_valid     = 1'b1;
                o_cmd.end_phase = i_stat.last_bit;
                o_cmd.next_bit  = i_out_ready & ~i_stat.last_bit;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_ready_excl, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "in ready while result pending")
    `ASSERT_NEXT(a_hi_to_lo, i_clk, i_rst_n, r_state == jbcd_pkg::S_HI && i_out_ready, r_state == jbcd_pkg::S_LO, "tck high phase not followed by low phase")
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, r_state == $past(r_state), "state moved while output stalled")
    `ASSERT_ALWAYS(a_bit_step, i_clk, i_rst_n, !(o_cmd.next_bit && o_cmd.end_phase), "bit advance on final phase")

endmodule

`default_nettype wire

// ===== sv/jtag_byte_command_decoder.sv =====
// top level: jtag byte command decoder, controller plus datapath
//
// channel   dir   handshake       payload
// i_in      in    valid/ready     host_byte, tdo_bits
// o_out     out   valid/ready     tck, tms, tdi, nce_pin, ncs_pin, output_enable,
//                                 read_valid, read_byte, last
//
// shift entry command: accepted while idle, no result
// bit-bang command: accepted while idle, then one result held until taken
// shift data byte: accepted while idle, then 16 results, one per tck phase,
// each held until taken
// one item in flight; the controller's phase loop sets the rate
// reset (synchronous, active low) clears pins, shift count and read-back flag
`default_nettype none

module jtag_byte_command_decoder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    jbcd_in_if.sink    i_in,
    jbcd_out_if.source o_out
);

    jbcd_pkg::t_dp_cmd  w_cmd;
    jbcd_pkg::t_dp_stat w_stat;

    jbcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    jbcd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_host_byte     (i_in.host_byte),
        .i_tdo_bits      (i_in.tdo_bits),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_tck           (o_out.tck),
        .o_tms           (o_out.tms),
        .o_tdi           (o_out.tdi),
        .o_nce_pin       (o_out.nce_pin),
        .o_ncs_pin       (o_out.ncs_pin),
        .o_output_enable (o_out.output_enable),
        .o_read_valid    (o_out.read_valid),
        .o_read_byte     (o_out.read_byte),
        .o_last          (o_out.last)
    );

endmodule

`default_nettype wire

// ===== dv/jbcd_tb_pkg.sv =====
// testbench package: pin phase type and the byte decoder scoreboard
`timescale 1ns / 100ps
`default_nettype none

package jbcd_tb_pkg;

    import jbcd_pkg::*;

    localparam int unsigned PIN_TCK = 0;
    localparam int unsigned PIN_TMS = 1;
    localparam int unsigned PIN_NCE = 2;
    localparam int unsigned PIN_NCS = 3;
    localparam int unsigned PIN_TDI = 4;
    localparam int unsigned PIN_OE  = 5;

    localparam logic DATAOUT_LEVEL = 1'b1;
    localparam int unsigned MAX_PRINTED = 40;

    typedef struct packed {
        logic              tck;
        logic              tms;
        logic              tdi;
        logic              nce_pin;
        logic              ncs_pin;
        logic              output_enable;
        logic              read_valid;
        logic [BYTE_W-1:0] read_byte;
        logic              last;
    } t_pin_phase;

    class jbcd_scoreboard;
        t_pin_phase         expected_phases[$];
        logic [COUNT_W-1:0] bytes_to_shift;
        logic               read_back;
        logic [PIN_W-1:0]   pins;
        int unsigned        errors;
        int unsigned        phases_checked;

        function new();
            bytes_to_shift = '0;
            read_back      = 1'b0;
            pins           = '0;
            errors         = 0;
            phases_checked = 0;
        endfunction

        function t_pin_phase make_phase(logic [PIN_W-1:0] p, logic rv,
                                        logic [BYTE_W-1:0] rb, logic lst);
            t_pin_phase ph;
            ph.tck           = p[PIN_TCK];
            ph.tms           = p[PIN_TMS];
            ph.tdi           = p[PIN_TDI];
            ph.nce_pin       = p[PIN_NCE];
            ph.ncs_pin       = p[PIN_NCS];
            ph.output_enable = p[PIN_OE];
            ph.read_valid    = rv;
            ph.read_byte     = rv ? rb : '0;
            ph.last          = lst;
            return ph;
        endfunction

        function void note_item(logic [BYTE_W-1:0] host_byte, logic [BYTE_W-1:0] tdo_bits);
            logic [BYTE_W-1:0] captured;
            logic [PIN_W-1:0]  tck_high;
            logic              ncs_level;
            logic              final_bit;
            if (bytes_to_shift != '0) begin
                ncs_level = pins[PIN_NCS];
                captured  = '0;
                bytes_to_shift = bytes_to_shift - COUNT_W'(1);
                for (int i = 0; i < BYTE_W; i++) begin
                    captured[i]   = ncs_level ? tdo_bits[i] : DATAOUT_LEVEL;
                    pins[PIN_TCK] = 1'b0;
                    pins[PIN_TDI] = host_byte[i];
                    tck_high      = pins;
                    tck_high[PIN_TCK] = 1'b1;
                    final_bit     = (i == int'(LAST_BIT_IDX));
                    expected_phases.push_back(make_phase(tck_high, 1'b0, '0, 1'b0));
                    expected_phases.push_back(
                        make_phase(pins, final_bit && read_back, captured, final_bit));
                end
            end else begin
                read_back = host_byte[READ_BIT];
                if (host_byte[SHIFT_CMD_BIT]) begin
                    bytes_to_shift = host_byte[COUNT_W-1:0];
                end else begin
                    pins = host_byte[PIN_W-1:0];
                    expected_phases.push_back(
                        make_phase(pins, read_back, READ_STATUS | {7'b0, tdo_bits[0]}, 1'b1));
                end
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("MISMATCH at %0t: %s", $realtime, what);
            end
        endtask

        task compare_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("phase %0d %s: got %0h, expected %0h",
                                          phases_checked, name, got, want));
            end
        endtask

        task check_phase(t_pin_phase got);
            t_pin_phase want;
            if (expected_phases.size() == 0) begin
                report_mismatch($sformatf("unexpected pin phase %p", got));
                return;
            end
            want = expected_phases.pop_front();
            compare_field("tck", BYTE_W'(got.tck), BYTE_W'(want.tck));
            compare_field("tms", BYTE_W'(got.tms), BYTE_W'(want.tms));
            compare_field("tdi", BYTE_W'(got.tdi), BYTE_W'(want.tdi));
            compare_field("nce_pin", BYTE_W'(got.nce_pin), BYTE_W'(want.nce_pin));
            compare_field("ncs_pin", BYTE_W'(got.ncs_pin), BYTE_W'(want.ncs_pin));
            compare_field("output_enable", BYTE_W'(got.output_enable),
                          BYTE_W'(want.output_enable));
            compare_field("read_valid", BYTE_W'(got.read_valid), BYTE_W'(want.read_valid));
            compare_field("read_byte", got.read_byte, want.read_byte);
            compare_field("last", BYTE_W'(got.last), BYTE_W'(want.last));
            phases_checked++;
        endtask

        function int unsigned pending();
            return expected_phases.size();
        endfunction
    endclass

endpackage

`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench top: drives host bytes, stalls the pin phase channel, checks every phase
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    import jbcd_pkg::*;
    import jbcd_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 160;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    int unsigned random_items = 0;

    jbcd_in_if  in_if ();
    jbcd_out_if out_if ();

    jbcd_scoreboard sb = new();

    jtag_byte_command_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.host_byte = '0;
        in_if.tdo_bits  = '0;
        out_if.ready    = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int unsigned pick_idle();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // stretches with random stalls, broken by stretches with no new stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_if.ready <= 1'b0;
        end else if ((cycle_count / 900) % 4 == 2 || $urandom_range(0, 99) < 70) begin
            out_if.ready <= 1'b1;
        end else begin
            stall_left = pick_idle() - 1;
            out_if.ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_phase('{
                tck:           out_if.tck,
                tms:           out_if.tms,
                tdi:           out_if.tdi,
                nce_pin:       out_if.nce_pin,
                ncs_pin:       out_if.ncs_pin,
                output_enable: out_if.output_enable,
                read_valid:    out_if.read_valid,
                read_byte:     out_if.read_byte,
                last:          out_if.last
            });
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] host_byte,
                             input logic [BYTE_W-1:0] tdo_bits);
        int unsigned gap;
        gap = 0;
        if ((cycle_count / 700) % 4 != 1 && $urandom_range(0, 99) >= 60) begin
            gap = pick_idle();
        end
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.host_byte <= host_byte;
        in_if.tdo_bits  <= tdo_bits;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_item(host_byte, tdo_bits);
    endtask

    task automatic send_shift(input logic read_back, input logic [COUNT_W-1:0] count);
        logic [BYTE_W-1:0] cmd;
        cmd = '0;
        cmd[SHIFT_CMD_BIT]   = 1'b1;
        cmd[READ_BIT]        = read_back;
        cmd[COUNT_W-1:0]     = count;
        send_byte(cmd, BYTE_W'($urandom));
        for (int i = 0; i < int'(count); i++) begin
            send_byte(BYTE_W'($urandom), BYTE_W'($urandom));
        end
        random_items += 1 + 32'(count);
    endtask

    initial begin
        logic [BYTE_W-1:0]  pins_cmd;
        logic [COUNT_W-1:0] count;
        int unsigned        pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bit-bang extremes, with and without read
        send_byte(8'h40, 8'h00);
        send_byte(8'h7F, 8'hFF);
        send_byte(8'h3F, 8'h00);
        // shift entry with count zero stays in bit-bang mode
        send_byte(8'h80, 8'hFF);
        send_byte(8'hC0, 8'h01);
        // shift with read-back and ncs high, tdo sampled
        send_byte(8'h48, 8'h01);
        send_byte(8'hC2, 8'h00);
        send_byte(8'h00, 8'hFF);
        send_byte(8'hFF, 8'h00);
        // ncs low, captured bits read as dataout
        send_byte(8'h00, 8'h00);
        send_byte(8'hC1, 8'h00);
        send_byte(8'hA5, 8'h00);
        // shift without read-back
        send_byte(8'h81, 8'hFF);
        send_byte(8'h5A, 8'h3C);
        // other pins hold their levels through a shift
        send_byte(8'h2E, 8'h00);
        send_byte(8'hC1, 8'hFF);
        send_byte(8'h96, 8'h69);
        send_byte(8'h01, 8'h00);
        send_byte(8'hC1, 8'h00);
        send_byte(8'h3C, 8'hC3);

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                pins_cmd = BYTE_W'($urandom);
                pins_cmd[SHIFT_CMD_BIT] = 1'b0;
                send_byte(pins_cmd, BYTE_W'($urandom));
                random_items++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    count = '1;
                end else if (pick < 10) begin
                    count = '0;
                end else begin
                    count = COUNT_W'($urandom_range(1, 4));
                end
                send_shift(1'($urandom_range(0, 1)), count);
            end
        end

        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/jbcd_pkg.sv
sv/jbcd_if.sv
sv/jbcd_dp.sv
sv/jbcd_ctrl.sv
sv/jtag_byte_command_decoder.sv
dv/jbcd_tb_pkg.sv
dv/tb_top.sv
